FILE: hdl/gbts_pkg.sv
// ----------------------------------------------------------------------------
// gbts_pkg
// shared types and constants of the gap buffer text store
// ----------------------------------------------------------------------------
`default_nettype none

package gbts_pkg;

   localparam int CAPACITY = 4096;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int LEN_W    = 13;
   localparam int BYTE_W   = 8;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_MOVE   = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   // one stage of the byte shifting chain
   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] addr;
      logic [BYTE_W-1:0] data;
   } cell_type;

endpackage

`default_nettype wire

FILE: hdl/gap_buffer_text_store_top.sv
// ----------------------------------------------------------------------------
// gap_buffer_text_store_top
// fixed-capacity gap buffer of text bytes driven by an operation stream
// ----------------------------------------------------------------------------
// One item at a time is worked on. Insert, delete, a move to the current gap
// position and any failed operation pass from acceptance to the result state
// and then the result register; a read first passes through the registered
// store read. A move that shifts bytes moves them across the gap one per
// cycle through a two-cell chain that reads the store, holds the byte and
// writes it back through the single write port, and the chain drains before
// the result is given. A new item is taken while the last result still
// waits. There is no clearing pass; the store contents are undefined until
// written.
`default_nettype none

module gap_buffer_text_store_top
   import gbts_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [23:0] req_tdata,  // char_in[7:0], position[20:8], zero
   input  wire logic [1:0]  req_tuser,  // op[1:0]
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [23:0] rsp_tdata   // char_out[7:0], text_length[20:8],
                                        // status[22:21], zero
);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_READ   = 5'b00010,
      S_MOVE   = 5'b00100,
      S_DRAIN  = 5'b01000,
      S_RESULT = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [LEN_W-1:0]  gap_pos_ff, gap_pos_in;
   logic [LEN_W-1:0]  gap_len_ff, gap_len_in;
   logic [LEN_W-1:0]  cnt_ff, cnt_in;
   logic [ADDR_W-1:0] src_ff, src_in;
   logic              up_ff, up_in;
   logic [BYTE_W-1:0] res_char_ff, res_char_in;
   status_type        res_status_ff, res_status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [23:0]       rsp_data_ff, rsp_data_in;

   logic              accept;
   op_type            req_op;
   logic [BYTE_W-1:0] req_char;
   logic [LEN_W-1:0]  req_pos;
   logic [LEN_W-1:0]  text_len;
   logic [LEN_W-1:0]  phys;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [BYTE_W-1:0] wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [BYTE_W-1:0] rd_data;
   logic              ins_wr;

   cell_type          cell0_in, cell0_out, cell1_in, cell1_out;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign req_op     = op_type'(req_tuser);
   assign req_char   = req_tdata[7:0];
   assign req_pos    = req_tdata[20:8];
   assign text_len   = LEN_W'(CAPACITY) - gap_len_ff;
   // logical position to store address, skipping over the gap
   assign phys       = (req_pos >= gap_pos_ff) ? (req_pos + gap_len_ff) : req_pos;

   gbts_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   gbts_cell u_cell0 (
      .clock    (clock),
      .reset    (reset),
      .cell_in  (cell0_in),
      .cell_out (cell0_out)
   );

   gbts_cell u_cell1 (
      .clock    (clock),
      .reset    (reset),
      .cell_in  (cell1_in),
      .cell_out (cell1_out)
   );

   // second cell picks up the byte the first cell's read brought back
   assign cell1_in = '{valid: cell0_out.valid, addr: cell0_out.addr, data: rd_data};

   assign wr_en   = ins_wr || cell1_out.valid;
   assign wr_addr = cell1_out.valid ? cell1_out.addr : gap_pos_ff[ADDR_W-1:0];
   assign wr_data = cell1_out.valid ? cell1_out.data : req_char;

   always_comb begin
      state_in      = state_ff;
      gap_pos_in    = gap_pos_ff;
      gap_len_in    = gap_len_ff;
      cnt_in        = cnt_ff;
      src_in        = src_ff;
      up_in         = up_ff;
      res_char_in   = res_char_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      ins_wr        = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = phys[ADDR_W-1:0];
      cell0_in      = '{valid: 1'b0, addr: '0, data: '0};

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_char_in   = '0;
               res_status_in = ST_OK;
               state_in      = S_RESULT;
               unique case (req_op)
                  OP_INSERT: begin
                     if (gap_len_ff == '0) begin
                        res_status_in = ST_FULL;
                     end else begin
                        ins_wr     = 1'b1;
                        gap_pos_in = gap_pos_ff + 1'b1;
                        gap_len_in = gap_len_ff - 1'b1;
                     end
                  end
                  OP_DELETE: begin
                     if (gap_pos_ff == '0) begin
                        res_status_in = ST_RANGE;
                     end else begin
                        gap_pos_in = gap_pos_ff - 1'b1;
                        gap_len_in = gap_len_ff + 1'b1;
                     end
                  end
                  OP_MOVE: begin
                     if (req_pos > text_len) begin
                        res_status_in = ST_RANGE;
                     end else if (req_pos < gap_pos_ff) begin
                        // bytes below the gap move up, highest first
                        gap_pos_in = req_pos;
                        cnt_in     = gap_pos_ff - req_pos;
                        src_in     = ADDR_W'(gap_pos_ff - 1'b1);
                        up_in      = 1'b0;
                        state_in   = S_MOVE;
                     end else if (req_pos > gap_pos_ff) begin
                        // bytes above the gap move down, lowest first
                        gap_pos_in = req_pos;
                        cnt_in     = req_pos - gap_pos_ff;
                        src_in     = ADDR_W'(gap_pos_ff + gap_len_ff);
                        up_in      = 1'b1;
                        state_in   = S_MOVE;
                     end
                  end
                  OP_READ: begin
                     if (req_pos >= text_len) begin
                        res_status_in = ST_RANGE;
                     end else begin
                        rd_en    = 1'b1;
                        state_in = S_READ;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_READ: begin
            res_char_in = rd_data;
            state_in    = S_RESULT;
         end
         S_MOVE: begin
            rd_en    = 1'b1;
            rd_addr  = src_ff;
            cell0_in = '{valid: 1'b1,
                         addr: up_ff ? ADDR_W'(src_ff - gap_len_ff)
                                     : ADDR_W'(src_ff + gap_len_ff),
                         data: '0};
            src_in   = up_ff ? (src_ff + 1'b1) : (src_ff - 1'b1);
            cnt_in   = cnt_ff - 1'b1;
            if (cnt_ff == LEN_W'(1)) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!cell0_out.valid && !cell1_out.valid) begin
               state_in = S_RESULT;
            end
         end
         S_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, res_status_ff, text_len, res_char_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         gap_pos_ff   <= '0;
         gap_len_ff   <= LEN_W'(CAPACITY);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gap_pos_ff   <= gap_pos_in;
         gap_len_ff   <= gap_len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff        <= cnt_in;
      src_ff        <= src_in;
      up_ff         <= up_in;
      res_char_ff   <= res_char_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_chain_only_in_move: assert property (@(posedge clock) disable iff (reset)
      cell1_out.valid |-> (state_ff == S_MOVE || state_ff == S_DRAIN))
      else $error("shift chain writes outside a move");

   a_gap_in_store: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, gap_pos_ff} + {1'b0, gap_len_ff}) <= (LEN_W + 1)'(CAPACITY))
      else $error("gap runs past the end of the store");

   a_item_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != S_IDLE)
      else $error("accepted item did not start work");

   a_result_after_drain: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RESULT |-> !cell0_out.valid && !cell1_out.valid)
      else $error("result issued while bytes still shifting");

   a_no_insert_during_shift: assert property (@(posedge clock) disable iff (reset)
      ins_wr |-> !cell1_out.valid)
      else $error("insert collides with shift write");

endmodule

`default_nettype wire

FILE: hdl/gbts_ram.sv
// ----------------------------------------------------------------------------
// gbts_ram
// single write port, single read port byte store with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module gbts_ram
   import gbts_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [BYTE_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [BYTE_W-1:0] rd_data
);

   logic [BYTE_W-1:0] mem [CAPACITY];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hdl/gbts_cell.sv
// ----------------------------------------------------------------------------
// gbts_cell
// one stage of the shifting chain: holds a target address and a byte
// ----------------------------------------------------------------------------
`default_nettype none

module gbts_cell
   import gbts_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire cell_type cell_in,
   output      cell_type cell_out
);

   logic              valid_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [BYTE_W-1:0] data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= cell_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= cell_in.addr;
      data_ff <= cell_in.data;
   end

   assign cell_out = '{valid: valid_ff, addr: addr_ff, data: data_ff};

endmodule

`default_nettype wire
